>>> sv/arle_pkg.sv
// ============================================================================
// Antialiased line raster engine package
// Shared transfer payload types, operation codes and pixel unit interface.
// ============================================================================
package arle_pkg;

    // Internal coordinate width: 16-bit inputs plus headroom for differences.
    localparam int COORD_W = 18;
    localparam int CFG_W   = 9;
    localparam int CHAN_W  = 8;

    localparam logic [2:0] OP_PIXEL = 3'd0;
    localparam logic [2:0] OP_LINE  = 3'd1;
    localparam logic [2:0] OP_HSPAN = 3'd2;
    localparam logic [2:0] OP_VSPAN = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [15:0] x_start;
        logic signed [15:0] y_start;
        logic signed [15:0] x_end;
        logic signed [15:0] y_end;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
        logic       read_valid;
    } out_item_t;

    typedef struct packed {
        coord_t     x;
        coord_t     y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       rd;
    } pix_req_t;

    typedef struct packed {
        logic       done;
        logic       hit;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_rsp_t;

endpackage

>>> sv/arle_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ============================================================================
module arle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 96000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/arle_div.sv
// ============================================================================
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module arle_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 17,
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_next;

    always_comb begin
        rem_sh   = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> sv/arle_pix.sv
// ============================================================================
// Pixel unit
// Owns the frame store: clearing pass, clipping, addressing and blended
// read-modify-write of one pixel per request.
// ============================================================================
module arle_pix #(
    parameter int MAX_WIDTH     = 400,
    parameter int SCREEN_HEIGHT = 240,
    localparam int VW           = $clog2(MAX_WIDTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    output logic               req_ready,
    input  arle_pkg::pix_req_t req,
    input  logic [VW-1:0]      vis_w,
    output logic               clearing,
    output arle_pkg::pix_rsp_t rsp
);
    import arle_pkg::*;

    localparam int DEPTH = MAX_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHECK, S_READ, S_WRITE} state_t;

    state_t       state_reg;
    pix_req_t     req_reg;
    pix_rsp_t     rsp_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] clr_reg;
    logic [15:0]  sum_reg [3];

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [23:0]   ram_rdata;

    logic          vis;
    logic [AW-1:0] addr_c;
    logic [7:0]    src [3];
    logic [7:0]    dst [3];
    logic [7:0]    inv_a;
    logic [15:0]   sum_c [3];
    logic [16:0]   q_c [3];

    always_comb begin
        vis = !req_reg.x[COORD_W-1] && !req_reg.y[COORD_W-1]
            && (req_reg.x[COORD_W-2:0] < (COORD_W-1)'(vis_w))
            && (req_reg.y[COORD_W-2:0] < (COORD_W-1)'(SCREEN_HEIGHT));
        addr_c = AW'(req_reg.x[XW-1:0]) * AW'(SCREEN_HEIGHT)
               + AW'(SCREEN_HEIGHT - 1) - AW'(req_reg.y[YW-1:0]);
        src[0] = req_reg.red;
        src[1] = req_reg.green;
        src[2] = req_reg.blue;
        dst[0] = ram_rdata[23:16];
        dst[1] = ram_rdata[15:8];
        dst[2] = ram_rdata[7:0];
        inv_a  = 8'd255 - req_reg.alpha;
        for (int c = 0; c < 3; c++) begin
            sum_c[c] = 16'(dst[c] * inv_a) + 16'(src[c] * req_reg.alpha);
            // Exact division by 255 for sums below 65535.
            q_c[c] = (17'(sum_reg[c]) + 17'd1 + 17'(sum_reg[c] >> 8)) >> 8;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {q_c[0][7:0], q_c[1][7:0], q_c[2][7:0]};
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_CHECK: begin
                ram_waddr = addr_c;
                ram_wdata = {req_reg.red, req_reg.green, req_reg.blue};
                ram_we    = vis && !req_reg.rd && (req_reg.alpha == 8'd255);
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = addr_c;
    assign req_ready = (state_reg == S_IDLE);
    assign clearing  = (state_reg == S_CLEAR);
    assign rsp       = rsp_reg;

    arle_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            rsp_reg   <= '0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    // The completion flag lives for this one idle cycle.
                    rsp_reg.done <= 1'b0;
                    if (req_valid) begin
                        req_reg   <= req;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    addr_reg <= addr_c;
                    if (!vis || (!req_reg.rd && (req_reg.alpha == 8'd0
                                 || req_reg.alpha == 8'd255))) begin
                        rsp_reg   <= {1'b1, 25'd0};
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    if (req_reg.rd) begin
                        rsp_reg   <= {1'b1, 1'b1, ram_rdata};
                        state_reg <= S_IDLE;
                    end else begin
                        for (int c = 0; c < 3; c++) begin
                            sum_reg[c] <= sum_c[c];
                        end
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    rsp_reg   <= {1'b1, 25'd0};
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/antialiased_line_raster_engine.sv
// ============================================================================
// Antialiased line raster engine
// Draws blended pixels, Wu antialiased lines and spans into a column-major
// RGB frame store, and reads pixels back.
// ============================================================================
//
//  Channel   Direction  Ports                          Content
//  --------  ---------  -----------------------------  -------------------------
//  s_        in         s_valid, s_ready, s_data       one drawing command
//  m_        out        m_valid, m_ready, m_data       one result per command
//  cfg_      in         cfg_wr_en, cfg_wr_data         screen width register
//
// After reset the frame store is cleared one entry per cycle, through all
// MAX_WIDTH*SCREEN_HEIGHT entries (96000 by default); s_ready stays low until
// it is done. Each pixel goes through the pixel unit as a read-modify-write on
// the store's single read and write port: a visible blended pixel passes the
// check, read and write states, a read the check and read states, and a solid
// or dropped one ends in the check state. A line first forms its gradient in
// the serial divider, then plots two pixels per column that lies on screen and
// skips a column that does not. Spans are clipped along their varying axis
// first, so positions off screen on that axis never reach the pixel unit. A
// command is accepted while the previous result still waits in the output
// register; a stalled m_ready only holds the engine when the next result is ready.
//
module antialiased_line_raster_engine #(
    parameter int MAX_WIDTH     = 400,
    parameter int SCREEN_HEIGHT = 240,
    parameter int FRAC_BITS     = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  arle_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output arle_pkg::out_item_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [arle_pkg::CFG_W-1:0]    cfg_wr_data
);
    import arle_pkg::*;

    localparam int VW    = $clog2(MAX_WIDTH + 1);
    localparam int DEN_W = 17;
    localparam int NUM_W = DEN_W + FRAC_BITS;
    localparam int ACC_W = FRAC_BITS + COORD_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_SISSUE, ST_SWAIT, ST_LSWAP, ST_LORDER, ST_LDIV,
        ST_LCOL, ST_LP1, ST_LW1, ST_LP2, ST_LW2, ST_FIN
    } state_t;

    state_t     state_reg;
    in_item_t   item_reg;
    out_item_t  res_reg;
    out_item_t  m_data_reg;
    logic       m_valid_reg;
    logic [CFG_W-1:0] cfg_reg;

    // Span walk: cur_reg runs along the varying axis, fix_reg is the other axis.
    coord_t     cur_reg, hi_reg, fix_reg;
    logic       vert_reg;
    logic       rd_reg;

    // Line state after the steep swap and endpoint ordering.
    coord_t     lx1_reg, ly1_reg, lx2_reg, ly2_reg;
    logic       steep_reg;
    logic       neg_reg;
    logic signed [ACC_W-1:0] acc_reg, grad_reg;
    coord_t     ip_reg;
    logic [7:0] a1_reg, a2_reg;

    // Visible width saturates at MAX_WIDTH.
    logic [11:0]   cfg_ext, vis_ext;
    logic [VW-1:0] vis_w;
    coord_t        lim_w;

    always_comb begin
        cfg_ext = 12'(cfg_reg);
        vis_ext = (cfg_ext > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : cfg_ext;
        vis_w   = vis_ext[VW-1:0];
        lim_w   = COORD_W'(vis_w);
    end

    coord_t xs, ys, xe, ye;
    assign xs = COORD_W'(item_reg.x_start);
    assign ys = COORD_W'(item_reg.y_start);
    assign xe = COORD_W'(item_reg.x_end);
    assign ye = COORD_W'(item_reg.y_end);

    // Span decode with clipping of the varying axis to the screen.
    coord_t sp_lo, sp_hi, sp_fix, sp_lim, sp_lo_c, sp_hi_c;
    logic   sp_vert;

    always_comb begin
        sp_vert = 1'b0;
        sp_fix  = ys;
        sp_lo   = xs;
        sp_hi   = xs;
        case (item_reg.operation)
            OP_HSPAN: begin
                sp_lo = (xs < xe) ? xs : xe;
                sp_hi = (xs < xe) ? xe : xs;
            end
            OP_VSPAN: begin
                sp_vert = 1'b1;
                sp_fix  = xs;
                sp_lo   = (ys < ye) ? ys : ye;
                sp_hi   = (ys < ye) ? ye : ys;
            end
            default: begin
                sp_lo = xs;
                sp_hi = xs;
            end
        endcase
        sp_lim  = sp_vert ? COORD_W'(SCREEN_HEIGHT) : lim_w;
        sp_lo_c = (sp_lo < 0) ? '0 : sp_lo;
        sp_hi_c = (sp_hi > sp_lim - 1) ? sp_lim - 1 : sp_hi;
    end

    // Steep test and swap of the raw endpoints.
    coord_t adx, ady;
    logic   steep_c;

    always_comb begin
        adx     = (xe > xs) ? xe - xs : xs - xe;
        ady     = (ye > ys) ? ye - ys : ys - ye;
        steep_c = ady > adx;
    end

    // Endpoint ordering and gradient operands.
    coord_t ox1, oy1, ox2, oy2, ldx, ldy, ldy_abs;
    logic   div_start;
    logic   div_done;
    logic [NUM_W-1:0] div_num, div_quo;

    always_comb begin
        if (lx1_reg > lx2_reg) begin
            ox1 = lx2_reg; oy1 = ly2_reg; ox2 = lx1_reg; oy2 = ly1_reg;
        end else begin
            ox1 = lx1_reg; oy1 = ly1_reg; ox2 = lx2_reg; oy2 = ly2_reg;
        end
        ldx       = ox2 - ox1;
        ldy       = oy2 - oy1;
        ldy_abs   = ldy[COORD_W-1] ? -ldy : ldy;
        div_num   = {ldy_abs[DEN_W-1:0], FRAC_BITS'(0)};
        div_start = (state_reg == ST_LORDER) && (ldx != '0);
    end

    arle_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (ldx[DEN_W-1:0]),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Per-column coverage: floor of the accumulator and the two alphas.
    logic [FRAC_BITS-1:0] fr;
    logic [FRAC_BITS:0]   inv_fr;
    logic [FRAC_BITS+8:0] cov1, cov2;
    logic                 major_ok;

    always_comb begin
        fr     = acc_reg[FRAC_BITS-1:0];
        inv_fr = {1'b1, FRAC_BITS'(0)} - {1'b0, fr};
        cov1   = (FRAC_BITS+9)'({inv_fr, 8'd0}) - (FRAC_BITS+9)'(inv_fr);
        cov2   = (FRAC_BITS+9)'({fr, 8'd0}) - (FRAC_BITS+9)'(fr);
        if (steep_reg) begin
            major_ok = (lx1_reg >= 0) && (lx1_reg < COORD_W'(SCREEN_HEIGHT));
        end else begin
            major_ok = (lx1_reg >= 0) && (lx1_reg < lim_w);
        end
    end

    // Requests to the pixel unit. For a steep line the axes swap back.
    logic     req_valid;
    logic     req_ready;
    logic     pix_clearing;
    pix_req_t req;
    pix_rsp_t rsp;
    coord_t   ip_sel;

    always_comb begin
        ip_sel    = (state_reg == ST_LP2) ? ip_reg + 1'b1 : ip_reg;
        req_valid = 1'b0;
        req.red   = item_reg.red;
        req.green = item_reg.green;
        req.blue  = item_reg.blue;
        req.alpha = item_reg.alpha;
        req.rd    = rd_reg;
        req.x     = vert_reg ? fix_reg : cur_reg;
        req.y     = vert_reg ? cur_reg : fix_reg;
        case (state_reg)
            ST_SISSUE: begin
                req_valid = 1'b1;
            end
            ST_LP1, ST_LP2: begin
                req_valid = 1'b1;
                req.rd    = 1'b0;
                req.alpha = (state_reg == ST_LP1) ? a1_reg : a2_reg;
                req.x     = steep_reg ? ip_sel : lx1_reg;
                req.y     = steep_reg ? lx1_reg : ip_sel;
            end
            default: begin
                req_valid = 1'b0;
            end
        endcase
    end

    arle_pix #(
        .MAX_WIDTH     (MAX_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_pix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .vis_w     (vis_w),
        .clearing  (pix_clearing),
        .rsp       (rsp)
    );

    assign s_ready = (state_reg == ST_IDLE) && !pix_clearing;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cfg_reg     <= CFG_W'(400);
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            // The finishing state reloads the output register itself.
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        item_reg  <= s_data;
                        res_reg   <= '0;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    rd_reg   <= (item_reg.operation == OP_READ);
                    vert_reg <= sp_vert;
                    fix_reg  <= sp_fix;
                    cur_reg  <= sp_lo_c;
                    hi_reg   <= sp_hi_c;
                    case (item_reg.operation)
                        OP_PIXEL, OP_HSPAN, OP_VSPAN, OP_READ: begin
                            state_reg <= (sp_lo_c > sp_hi_c) ? ST_FIN : ST_SISSUE;
                        end
                        OP_LINE: begin
                            state_reg <= ST_LSWAP;
                        end
                        default: begin
                            state_reg <= ST_FIN;
                        end
                    endcase
                end
                ST_SISSUE: begin
                    if (req_ready) begin
                        state_reg <= ST_SWAIT;
                    end
                end
                ST_SWAIT: begin
                    if (rsp.done) begin
                        if (rsp.hit) begin
                            res_reg <= {rsp.red, rsp.green, rsp.blue, 1'b1};
                        end
                        if (cur_reg == hi_reg) begin
                            state_reg <= ST_FIN;
                        end else begin
                            cur_reg   <= cur_reg + 1'b1;
                            state_reg <= ST_SISSUE;
                        end
                    end
                end
                ST_LSWAP: begin
                    steep_reg <= steep_c;
                    lx1_reg   <= steep_c ? ys : xs;
                    ly1_reg   <= steep_c ? xs : ys;
                    lx2_reg   <= steep_c ? ye : xe;
                    ly2_reg   <= steep_c ? xe : ye;
                    state_reg <= ST_LORDER;
                end
                ST_LORDER: begin
                    lx1_reg   <= ox1;
                    ly1_reg   <= oy1;
                    lx2_reg   <= ox2;
                    neg_reg   <= ldy[COORD_W-1];
                    state_reg <= (ldx == '0) ? ST_FIN : ST_LDIV;
                end
                ST_LDIV: begin
                    if (div_done) begin
                        grad_reg  <= neg_reg ? -ACC_W'(div_quo) : ACC_W'(div_quo);
                        acc_reg   <= ACC_W'(ly1_reg) <<< FRAC_BITS;
                        state_reg <= ST_LCOL;
                    end
                end
                ST_LCOL: begin
                    if (lx1_reg == lx2_reg) begin
                        state_reg <= ST_FIN;
                    end else if (!major_ok) begin
                        // Column is off screen: advance without plotting.
                        acc_reg <= acc_reg + grad_reg;
                        lx1_reg <= lx1_reg + 1'b1;
                    end else begin
                        ip_reg    <= acc_reg[ACC_W-1:FRAC_BITS];
                        a1_reg    <= cov1[FRAC_BITS+7:FRAC_BITS];
                        a2_reg    <= cov2[FRAC_BITS+7:FRAC_BITS];
                        state_reg <= ST_LP1;
                    end
                end
                ST_LP1: begin
                    if (req_ready) begin
                        state_reg <= ST_LW1;
                    end
                end
                ST_LW1: begin
                    if (rsp.done) begin
                        state_reg <= ST_LP2;
                    end
                end
                ST_LP2: begin
                    if (req_ready) begin
                        state_reg <= ST_LW2;
                    end
                end
                ST_LW2: begin
                    if (rsp.done) begin
                        acc_reg   <= acc_reg + grad_reg;
                        lx1_reg   <= lx1_reg + 1'b1;
                        state_reg <= ST_LCOL;
                    end
                end
                ST_FIN: begin
                    // Load the result once the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A command is never taken while the frame store is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pix_clearing)
        else $error("command accepted during clearing pass");

    // A new result appears only from the finishing state.
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside finishing state");

    // Pixel unit completions only arrive while the sequencer waits for one.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_SWAIT || state_reg == ST_LW1
                      || state_reg == ST_LW2))
        else $error("pixel completion outside a wait state");

    // Only a read command can return pixel data.
    a_hit_only_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.done && rsp.hit) |-> (item_reg.operation == OP_READ))
        else $error("pixel data returned for a drawing command");

endmodule
